>>> sv/bounded_ordered_list_engine_defines.svh
// Assertion macros shared by the ordered list engine RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BOLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BOLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/bole_pkg.sv
// Types and codes shared by the ordered list engine and its cells.
// Depends on nothing.
package bole_pkg;

  localparam int DATA_W = 32;

  typedef logic [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    REQ_PUSH_FRONT    = 3'd0,
    REQ_PUSH_BACK     = 3'd1,
    REQ_SORTED_INSERT = 3'd2,
    REQ_REMOVE        = 3'd3,
    REQ_REVERSE       = 3'd4,
    REQ_CLEAR         = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CM_HOLD,
    CM_INSERT,
    CM_REMOVE
  } cell_mode_t;

  typedef enum logic [1:0] {
    SEL_NONE,
    SEL_ALL,
    SEL_GE,
    SEL_EQ
  } hit_sel_t;

  typedef struct packed {
    cell_mode_t mode;
    hit_sel_t   sel;
    logic       rev;
    data_t      value;
  } cell_ctl_t;

endpackage

>>> sv/bole_cell.sv
// One storage cell of the ordered list: holds one entry and shifts with its neighbors.
// Depends on bole_pkg.
module bole_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic               clk,
  input  bole_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]   cnt,
  input  bole_pkg::data_t    left_data,
  input  bole_pkg::data_t    right_data,
  input  logic               pre_in,
  input  logic               suf_in,
  input  logic               left_suf,
  input  logic               any_hit,
  output logic               pre_out,
  output logic               suf_out,
  output bole_pkg::data_t    data_out
);
  import bole_pkg::*;

  localparam logic [CNT_W-1:0] POS = CNT_W'(IDX);

  data_t entry_r;
  data_t entry_nxt;
  logic  in_range;
  logic  hit;

  assign in_range = POS < cnt;

  always_comb begin
    unique case (ctl.sel)
      SEL_ALL: hit = in_range;
      SEL_GE:  hit = in_range && ($signed(entry_r) >= $signed(ctl.value));
      SEL_EQ:  hit = in_range && (entry_r == ctl.value);
      default: hit = 1'b0;
    endcase
  end

  assign pre_out  = pre_in | hit;
  assign suf_out  = suf_in | hit;
  assign data_out = entry_r;

  // In reversed orientation the logical front sits at the highest occupied cell.
  always_comb begin
    entry_nxt = entry_r;
    unique case (ctl.mode)
      CM_INSERT: begin
        if (!ctl.rev) begin
          if (pre_in) begin
            entry_nxt = left_data;
          end else if (hit || (POS == cnt)) begin
            entry_nxt = ctl.value;
          end
        end else begin
          if (!suf_out) begin
            entry_nxt = left_suf ? ctl.value : left_data;
          end
        end
      end
      CM_REMOVE: begin
        if (!ctl.rev) begin
          if (pre_out) begin
            entry_nxt = right_data;
          end
        end else begin
          if (!suf_in && any_hit) begin
            entry_nxt = right_data;
          end
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

>>> sv/bounded_ordered_list_engine.sv
// Top level of the ordered list engine: request decode, count, orientation and result.
// Depends on bole_pkg, bole_cell and bounded_ordered_list_engine_defines.svh.
//
//   channel   ports                               handshake
//   request   in_req_type, in_value               start high while busy low
//   result    out_status, out_count,              out_valid for one cycle
//             out_front_value, out_back_value
//
// A transaction is accepted at the edge where start is high and busy is low; every cell
// updates at that edge. Busy is high for the next cycle, while the front and back entries
// are read out of the cell row, and the result shows on the cycle after that.
// A new transaction is not accepted while busy is high, so it waits out that readout cycle.
// Reset clears the count, orientation and strobes; entries need no clearing.
// The receiver cannot stall.
`include "bounded_ordered_list_engine_defines.svh"

module bounded_ordered_list_engine #(
  parameter int CAPACITY = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_req_type,
  input  logic signed [31:0]  in_value,
  output logic                out_valid,
  output logic [1:0]          out_status,
  output logic [4:0]          out_count,
  output logic signed [31:0]  out_front_value,
  output logic signed [31:0]  out_back_value
);
  import bole_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;
  logic             phase_r, phase_nxt;
  status_t          status_r, status_nxt;
  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [4:0]       out_count_r;
  data_t            out_front_r, out_back_r;

  logic             accept;
  logic             full;
  cell_ctl_t        ctl;
  data_t            cell_q    [CAPACITY];
  data_t            left_d    [CAPACITY];
  data_t            right_d   [CAPACITY];
  logic             left_suf  [CAPACITY];
  logic             pre_c     [CAPACITY+1];
  logic             suf_c     [CAPACITY+1];
  logic             any_hit;
  logic [IDX_W-1:0] last_idx;
  data_t            first_q, last_q;

  assign busy    = phase_r;
  assign accept  = start && !busy;
  assign full    = cnt_r >= CNT_W'(CAPACITY);
  assign any_hit = pre_c[CAPACITY];

  assign pre_c[0]        = 1'b0;
  assign suf_c[CAPACITY] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_d[g]   = cell_q[g];
      assign left_suf[g] = 1'b1;
    end else begin : g_inner
      assign left_d[g]   = cell_q[g-1];
      assign left_suf[g] = suf_c[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d[g] = cell_q[g];
    end else begin : g_body
      assign right_d[g] = cell_q[g+1];
    end

    bole_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .cnt        (cnt_r),
      .left_data  (left_d[g]),
      .right_data (right_d[g]),
      .pre_in     (pre_c[g]),
      .suf_in     (suf_c[g+1]),
      .left_suf   (left_suf[g]),
      .any_hit    (any_hit),
      .pre_out    (pre_c[g+1]),
      .suf_out    (suf_c[g]),
      .data_out   (cell_q[g])
    );
  end

  always_comb begin
    ctl = '{mode: CM_HOLD, sel: SEL_NONE, rev: rev_r, value: data_t'(in_value)};
    if (accept) begin
      unique case (req_t'(in_req_type))
        REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_SORTED_INSERT: begin
          if (req_t'(in_req_type) == REQ_PUSH_FRONT) begin
            ctl.sel = SEL_ALL;
          end else if (req_t'(in_req_type) == REQ_SORTED_INSERT) begin
            ctl.sel = SEL_GE;
          end
          if (!full) begin
            ctl.mode = CM_INSERT;
          end
        end
        REQ_REMOVE: begin
          ctl.mode = CM_REMOVE;
          ctl.sel  = SEL_EQ;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    cnt_nxt    = cnt_r;
    rev_nxt    = rev_r;
    status_nxt = status_r;
    phase_nxt  = 1'b0;
    if (accept) begin
      phase_nxt  = 1'b1;
      status_nxt = ST_OK;
      unique case (req_t'(in_req_type))
        REQ_PUSH_FRONT, REQ_PUSH_BACK, REQ_SORTED_INSERT: begin
          if (full) begin
            status_nxt = ST_FULL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        REQ_REMOVE: begin
          if (any_hit) begin
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            status_nxt = ST_NOT_FOUND;
          end
        end
        REQ_REVERSE: begin
          rev_nxt = !rev_r;
        end
        REQ_CLEAR: begin
          cnt_nxt = '0;
          rev_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rev_r    <= 1'b0;
      phase_r  <= 1'b0;
      status_r <= ST_OK;
    end else begin
      cnt_r    <= cnt_nxt;
      rev_r    <= rev_nxt;
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
    end
  end

  assign last_idx = IDX_W'(cnt_r - 1'b1);
  assign first_q  = cell_q[0];
  assign last_q   = cell_q[last_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= phase_r;
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r) begin
      out_status_r <= status_r;
      out_count_r  <= 5'(cnt_r);
      if (cnt_r == '0) begin
        out_front_r <= '0;
        out_back_r  <= '0;
      end else begin
        out_front_r <= rev_r ? last_q : first_q;
        out_back_r  <= rev_r ? first_q : last_q;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_count       = out_count_r;
  assign out_front_value = $signed(out_front_r);
  assign out_back_value  = $signed(out_back_r);

  `BOLE_ASSERT_NEXT(a_busy_after_accept, accept, busy, "Accepted transaction did not raise busy.")
  `BOLE_ASSERT_NEXT(a_result_follows, phase_r, out_valid_r, "Readout cycle gave no result.")
  `BOLE_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CNT_W'(CAPACITY), "Entry count above capacity.")
  `BOLE_ASSERT_NOW(a_empty_zero, out_valid_r && (cnt_r == '0),
                   (out_front_r == '0) && (out_back_r == '0), "Empty list gave nonzero ends.")

endmodule
